// ===== src/cotrm_pkg.sv =====
// Shared types, codes and reset values for the clock offset tracker and rate monitor.
// No dependencies; every other file of the block but cotrm_chan_if imports this package.
package cotrm_pkg;

   localparam int WINDOW_DEPTH_DEF = 10;

   localparam int CSR_DATA_W = 56;
   localparam int CSR_IDX_W  = 2;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_LOW_RATE   = 2'd0;
   localparam csr_idx_type CSR_HIGH_RATE  = 2'd1;
   localparam csr_idx_type CSR_SKEW_LIMIT = 2'd2;
   localparam csr_idx_type CSR_UNIX_AFTER = 2'd3;

   localparam logic KIND_SYNC = 1'b0;
   localparam logic KIND_POLL = 1'b1;

   typedef logic [1:0] rate_status_type;
   localparam rate_status_type RATE_NORMAL    = 2'd0;
   localparam rate_status_type RATE_TOO_LOW   = 2'd1;
   localparam rate_status_type RATE_TOO_HIGH  = 2'd2;
   localparam rate_status_type RATE_NO_EVENTS = 2'd3;

   localparam logic [19:0] LOW_RATE_RESET   = 20'd9;
   localparam logic [19:0] HIGH_RATE_RESET  = 20'd11000;
   localparam logic [31:0] SKEW_LIMIT_RESET = 32'd2000000;
   localparam logic [55:0] UNIX_AFTER_RESET = 56'd1234567890000000;

   // events are scaled to millihertz against the window in ms
   localparam logic [19:0] EVENT_SCALE = 20'd1000000;

   typedef struct packed {
      logic [19:0] low_rate_limit_mhz;
      logic [19:0] high_rate_limit_mhz;
      logic [31:0] skew_limit_us;
      logic [55:0] unix_valid_after_us;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [47:0] local_time_ms;
      logic [31:0] remote_boot_ms;
      logic [55:0] remote_unix_us;
   } req_type;

   typedef struct packed {
      logic signed [63:0] tracked_offset_us;
      logic signed [63:0] skew_us;
      logic               resynced;
      logic               unix_time_valid;
      rate_status_type    rate_status;
      logic [31:0]        events_in_window;
      logic [47:0]        window_ms;
      logic [31:0]        sync_count;
      logic signed [63:0] last_skew_us;
      logic signed [63:0] skew_sum_us;
      logic [55:0]        last_unix_us;
   } rsp_type;

   // input register contents: offset already formed
   typedef struct packed {
      logic        kind;
      logic [47:0] local_time_ms;
      logic [55:0] remote_unix_us;
      logic [63:0] offset;
   } s1_type;

   typedef struct packed {
      logic    kind;
      rsp_type rsp;
   } s2_type;

   typedef struct packed {
      logic        step;
      logic        poll;
      logic        resync;
      logic [47:0] local_time_ms;
      logic [31:0] count;
   } win_cmd_type;

   typedef struct packed {
      logic [47:0] slot_time;
      logic [31:0] slot_count;
   } slot_type;

endpackage

// ===== src/cotrm_chan_if.sv =====
// Valid/ready channel carrying one payload word of a chosen type.
// Used for both the request and the response side; no dependencies.
interface cotrm_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/clock_offset_tracker_rate_monitor.sv =====
// Channel   | Direction | Word                      | Handshake
// req_ch    | in        | kind, local/boot/unix     | valid/ready
// rsp_ch    | out       | offset, skew, rate, stats | valid/ready
// csr_*     | in        | index, write data         | write enable, no back-pressure
//
// One word accepted per cycle unless the response side stalls; its result passes the
// input register, tracking stage, product register and output register. The tracking
// stage closes the offset/counter loop within itself, and the window ring is a memory
// with one write per poll word and one prefetched read per word. Reset clears all
// tracking state and the window valid bits, so no clearing pass is needed. A stalled
// response holds in the output register while earlier stages keep filling until full.
module clock_offset_tracker_rate_monitor #(
   parameter int WINDOW_DEPTH = cotrm_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  cotrm_pkg::csr_idx_type           csr_index,
   input  logic [cotrm_pkg::CSR_DATA_W-1:0] csr_wdata,
   cotrm_chan_if.sink                       req_ch,
   cotrm_chan_if.source                     rsp_ch
);
   import cotrm_pkg::*;

   cfg_type     cfg;
   s1_type      s1;
   logic        s1_valid, s1_ready;
   s2_type      s2;
   logic        s2_valid, s2_ready;
   win_cmd_type win_cmd;
   slot_type    slot;

   cotrm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cotrm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .s1       (s1),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready)
   );

   cotrm_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_window (
      .clock (clock),
      .reset (reset),
      .cmd   (win_cmd),
      .slot  (slot)
   );

   cotrm_track u_track (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s1       (s1),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .slot     (slot),
      .win_cmd  (win_cmd),
      .s2       (s2),
      .s2_valid (s2_valid),
      .s2_ready (s2_ready)
   );

   cotrm_rate u_rate (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s2       (s2),
      .s2_valid (s2_valid),
      .s2_ready (s2_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== src/cotrm_csr.sv =====
// Configuration registers: rate limits, skew limit and unix validity threshold.
// Depends on cotrm_pkg.
module cotrm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  cotrm_pkg::csr_idx_type              csr_index,
   input  logic [cotrm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output cotrm_pkg::cfg_type                  cfg
);
   import cotrm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LOW_RATE:   cfg_in.low_rate_limit_mhz  = csr_wdata[19:0];
            CSR_HIGH_RATE:  cfg_in.high_rate_limit_mhz = csr_wdata[19:0];
            CSR_SKEW_LIMIT: cfg_in.skew_limit_us       = csr_wdata[31:0];
            CSR_UNIX_AFTER: cfg_in.unix_valid_after_us = csr_wdata[55:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{low_rate_limit_mhz:  LOW_RATE_RESET,
                     high_rate_limit_mhz: HIGH_RATE_RESET,
                     skew_limit_us:       SKEW_LIMIT_RESET,
                     unix_valid_after_us: UNIX_AFTER_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/cotrm_front.sv =====
// Input register: takes a request word and forms offset = (local - boot) * 1000.
// Depends on cotrm_pkg and cotrm_chan_if.
module cotrm_front (
   input  logic              clock,
   input  logic              reset,
   cotrm_chan_if.sink        req_ch,
   output cotrm_pkg::s1_type s1,
   output logic              s1_valid,
   input  logic              s1_ready
);
   import cotrm_pkg::*;

   logic        valid_ff, valid_in;
   s1_type      s1_ff, s1_in;
   logic        load;
   logic [48:0] diff_short;
   logic [63:0] diff;

   assign req_ch.ready = !valid_ff || s1_ready;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      diff_short = {1'b0, req_ch.data.local_time_ms} - {17'b0, req_ch.data.remote_boot_ms};
      diff       = {{15{diff_short[48]}}, diff_short};
      s1_in.kind           = req_ch.data.kind;
      s1_in.local_time_ms  = req_ch.data.local_time_ms;
      s1_in.remote_unix_us = req_ch.data.remote_unix_us;
      // times 1000 as 1024 - 16 - 8, wrapping in 64 bits
      s1_in.offset = (diff << 10) - (diff << 4) - (diff << 3);
      valid_in = load ? 1'b1 : (s1_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= s1_in;
      end
   end

   assign s1       = s1_ff;
   assign s1_valid = valid_ff;

endmodule

// ===== src/cotrm_window.sv =====
// Sliding window ring of (time, count) slots held in a memory with registered read.
// Per-slot valid bits stand in for the resync fill. Depends on cotrm_pkg.
module cotrm_window #(
   parameter int WINDOW_DEPTH = cotrm_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cotrm_pkg::win_cmd_type cmd,
   output cotrm_pkg::slot_type    slot
);
   import cotrm_pkg::*;

   localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

   slot_type                mem [WINDOW_DEPTH];
   slot_type                rd_ff;
   slot_type                wr_data;
   logic                    wr_en;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [WINDOW_DEPTH-1:0] valid_ff, valid_in;
   logic [47:0]             base_ff, base_in;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      base_in  = base_ff;
      wr_en    = cmd.step && cmd.poll;
      wr_data  = slot_type'{slot_time: cmd.local_time_ms, slot_count: cmd.count};
      if (cmd.step && cmd.resync) begin
         // every slot now reads as (local time, zero)
         idx_in   = '0;
         valid_in = '0;
         base_in  = cmd.local_time_ms;
      end else if (wr_en) begin
         valid_in[idx_ff] = 1'b1;
         idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= '0;
         base_ff  <= '0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
         base_ff  <= base_in;
      end
   end

   // prefetch the slot the next word will see; forward a write to the same slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      if (wr_en && (idx_ff == idx_in)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[idx_in];
      end
   end

   assign slot = valid_ff[idx_ff] ? rd_ff :
                 slot_type'{slot_time: base_ff, slot_count: 32'd0};

endmodule

// ===== src/cotrm_track.sv =====
// Offset tracking stage: skew, resync decision, offset averaging and statistics.
// Drives the window ring and reads its current slot. Depends on cotrm_pkg.
module cotrm_track (
   input  logic                   clock,
   input  logic                   reset,
   input  cotrm_pkg::cfg_type     cfg,
   input  cotrm_pkg::s1_type      s1,
   input  logic                   s1_valid,
   output logic                   s1_ready,
   input  cotrm_pkg::slot_type    slot,
   output cotrm_pkg::win_cmd_type win_cmd,
   output cotrm_pkg::s2_type      s2,
   output logic                   s2_valid,
   input  logic                   s2_ready
);
   import cotrm_pkg::*;

   logic [63:0] offset_ff, offset_in;
   logic [31:0] count_ff, count_in;
   logic [63:0] last_skew_ff, last_skew_in;
   logic [63:0] skew_total_ff, skew_total_in;
   logic [55:0] last_unix_ff, last_unix_in;
   logic        valid_ff, valid_in;
   s2_type      s2_ff, s2_in;

   logic        step;
   logic        is_sync;
   logic        over;
   logic [63:0] skew;
   logic [63:0] mag;
   logic [64:0] avg_sum;
   logic [31:0] events;
   logic [47:0] window;
   logic [55:0] unix_cmp;

   assign s1_ready = !valid_ff || s2_ready;
   assign step     = s1_valid && s1_ready;

   always_comb begin
      is_sync = (s1.kind == KIND_SYNC);
      skew    = s1.offset - offset_ff;
      mag     = skew[63] ? (64'd0 - skew) : skew;
      over    = mag > {32'd0, cfg.skew_limit_us};
      avg_sum = {offset_ff[63], offset_ff} + {s1.offset[63], s1.offset};
      events  = count_ff - slot.slot_count;
      window  = s1.local_time_ms - slot.slot_time;

      offset_in     = offset_ff;
      count_in      = count_ff;
      last_skew_in  = last_skew_ff;
      skew_total_in = skew_total_ff;
      last_unix_in  = last_unix_ff;
      if (is_sync) begin
         last_unix_in = s1.remote_unix_us;
         if (over) begin
            offset_in     = s1.offset;
            count_in      = '0;
            skew_total_in = '0;
         end else begin
            // floor of the mean: drop the low bit of the 65-bit sum
            offset_in     = avg_sum[64:1];
            count_in      = count_ff + 32'd1;
            last_skew_in  = skew;
            skew_total_in = skew_total_ff + skew;
         end
      end

      unix_cmp = is_sync ? s1.remote_unix_us : last_unix_ff;

      s2_in.kind                  = s1.kind;
      s2_in.rsp.tracked_offset_us = offset_in;
      s2_in.rsp.skew_us           = is_sync ? skew : 64'd0;
      s2_in.rsp.resynced          = is_sync && over;
      s2_in.rsp.unix_time_valid   = unix_cmp > cfg.unix_valid_after_us;
      s2_in.rsp.rate_status       = RATE_NORMAL;
      s2_in.rsp.events_in_window  = is_sync ? 32'd0 : events;
      s2_in.rsp.window_ms         = is_sync ? 48'd0 : window;
      s2_in.rsp.sync_count        = count_in;
      s2_in.rsp.last_skew_us      = last_skew_in;
      s2_in.rsp.skew_sum_us       = skew_total_in;
      s2_in.rsp.last_unix_us      = last_unix_in;

      win_cmd.step          = step;
      win_cmd.poll          = !is_sync;
      win_cmd.resync        = is_sync && over;
      win_cmd.local_time_ms = s1.local_time_ms;
      win_cmd.count         = count_ff;

      valid_in = step ? 1'b1 : (s2_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         count_ff      <= '0;
         last_skew_ff  <= '0;
         skew_total_ff <= '0;
         last_unix_ff  <= '0;
         valid_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (step) begin
            offset_ff     <= offset_in;
            count_ff      <= count_in;
            last_skew_ff  <= last_skew_in;
            skew_total_ff <= skew_total_in;
            last_unix_ff  <= last_unix_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s2_ff <= s2_in;
      end
   end

   assign s2       = s2_ff;
   assign s2_valid = valid_ff;

endmodule

// ===== src/cotrm_rate.sv =====
// Rate check: registered products of events and window against the limits,
// then the compare into the output register. Depends on cotrm_pkg and cotrm_chan_if.
module cotrm_rate (
   input  logic               clock,
   input  logic               reset,
   input  cotrm_pkg::cfg_type cfg,
   input  cotrm_pkg::s2_type  s2,
   input  logic               s2_valid,
   output logic               s2_ready,
   cotrm_chan_if.source       rsp_ch
);
   import cotrm_pkg::*;

   logic        v3_ff, v3_in;
   logic        v4_ff, v4_in;
   logic        ready4;
   logic        load3, load4;

   s2_type      s3_ff;
   logic        none_ff;
   logic [51:0] ev_prod_ff, ev_prod;
   logic [67:0] lo_prod_ff, lo_prod;
   logic [67:0] hi_prod_ff, hi_prod;
   rsp_type     rsp_ff, rsp_in;
   logic [67:0] ev_wide;

   assign ready4   = !v4_ff || rsp_ch.ready;
   assign s2_ready = !v3_ff || ready4;
   assign load3    = s2_valid && s2_ready;
   assign load4    = v3_ff && ready4;

   always_comb begin
      ev_prod = 52'(s2.rsp.events_in_window) * 52'(EVENT_SCALE);
      lo_prod = 68'(cfg.low_rate_limit_mhz) * 68'(s2.rsp.window_ms);
      hi_prod = 68'(cfg.high_rate_limit_mhz) * 68'(s2.rsp.window_ms);
      v3_in   = load3 ? 1'b1 : (ready4 ? 1'b0 : v3_ff);
      v4_in   = load4 ? 1'b1 : (rsp_ch.ready ? 1'b0 : v4_ff);
   end

   always_comb begin
      ev_wide = 68'(ev_prod_ff);
      rsp_in  = s3_ff.rsp;
      if (s3_ff.kind != KIND_POLL) begin
         rsp_in.rate_status = RATE_NORMAL;
      end else if (none_ff) begin
         rsp_in.rate_status = RATE_NO_EVENTS;
      end else if (ev_wide < lo_prod_ff) begin
         rsp_in.rate_status = RATE_TOO_LOW;
      end else if (ev_wide > hi_prod_ff) begin
         rsp_in.rate_status = RATE_TOO_HIGH;
      end else begin
         rsp_in.rate_status = RATE_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         s3_ff      <= s2;
         none_ff    <= (s2.rsp.events_in_window == 32'd0);
         ev_prod_ff <= ev_prod;
         lo_prod_ff <= lo_prod;
         hi_prod_ff <= hi_prod;
      end
      if (load4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid = v4_ff;
   assign rsp_ch.data  = rsp_ff;

endmodule

// ===== src/cotrm_checker.sv =====
// Port-level checks on the response channel of the tracker, bound to the top level.
// Depends on cotrm_pkg and clock_offset_tracker_rate_monitor.
module cotrm_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cotrm_pkg::rsp_type rsp_data
);
   import cotrm_pkg::*;

   // output register empties on reset
   a_idle_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   // a resync clears the sync count and skew sum and is never a poll
   a_resync_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.resynced |->
         rsp_data.sync_count == 32'd0 && rsp_data.skew_sum_us == 64'sd0 &&
         rsp_data.events_in_window == 32'd0 && rsp_data.window_ms == 48'd0 &&
         rsp_data.rate_status == RATE_NORMAL)
      else $error("resync word carries stale statistics or rate fields");

   a_no_events_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rate_status == RATE_NO_EVENTS |->
         rsp_data.events_in_window == 32'd0 && rsp_data.skew_us == 64'sd0 &&
         !rsp_data.resynced)
      else $error("no-events status with events or sync fields set");

endmodule

bind clock_offset_tracker_rate_monitor cotrm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

// ===== tb/clock_offset_tracker_rate_monitor_tb.sv =====
// Self-checking testbench for clock_offset_tracker_rate_monitor: offset tracking,
// resync, skew statistics and window rate checks against an in-bench tracker model.
// Depends on cotrm_pkg, cotrm_chan_if and clock_offset_tracker_rate_monitor from the block's sources.
`timescale 1ns / 100ps

module clock_offset_tracker_rate_monitor_tb;
   import cotrm_pkg::*;

   localparam int DEPTH = WINDOW_DEPTH_DEF;

   typedef struct {
      req_type word;
      bit      hold;
   } backlog_entry_type;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_COMB} rx_mode_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   csr_idx_type           csr_index = CSR_LOW_RATE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cotrm_chan_if #(.payload_type(req_type)) req_if ();
   cotrm_chan_if #(.payload_type(rsp_type)) rsp_if ();

   clock_offset_tracker_rate_monitor DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_if.sink),
      .rsp_ch    (rsp_if.source)
   );

   // tracker copy: configuration, offset loop, statistics and window ring
   cfg_type     cfg_shadow;
   logic [63:0] trk_offset, trk_last_skew, trk_skew_sum;
   logic [31:0] trk_count;
   logic [55:0] trk_last_unix;
   logic [47:0] ring_time [DEPTH];
   logic [31:0] ring_count [DEPTH];
   int          ring_pos;

   backlog_entry_type word_backlog_q[$];
   rsp_type           rsp_due_q[$];
   int                fail_count = 0;

   // stimulus stream state
   logic [47:0] cur_local;
   logic [31:0] cur_boot;
   logic [55:0] cur_unix;
   int unsigned step_lo, step_hi, jitter_ms, poll_pct;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_type advance_tracker(req_type w);
      rsp_type      r;
      logic [63:0]  ofs, skew, mag;
      logic [64:0]  pair_sum;
      logic [31:0]  events;
      logic [47:0]  span;
      logic [127:0] scaled, low_bound, high_bound;
      r = '0;
      if (w.kind == KIND_SYNC) begin
         ofs = (64'(w.local_time_ms) - 64'(w.remote_boot_ms)) * 64'd1000;
         skew = ofs - trk_offset;
         mag = skew[63] ? -skew : skew;
         if (mag > 64'(cfg_shadow.skew_limit_us)) begin
            r.resynced = 1'b1;
            trk_offset = ofs;
            trk_count = '0;
            trk_skew_sum = '0;
            for (int i = 0; i < DEPTH; i++) begin
               ring_time[i] = w.local_time_ms;
               ring_count[i] = '0;
            end
            ring_pos = 0;
         end else begin
            // floor of the mean, taken on the 65-bit sum
            pair_sum = {trk_offset[63], trk_offset} + {ofs[63], ofs};
            trk_offset = pair_sum[64:1];
            trk_count = trk_count + 32'd1;
            trk_last_skew = skew;
            trk_skew_sum = trk_skew_sum + skew;
         end
         trk_last_unix = w.remote_unix_us;
         r.skew_us = skew;
         r.unix_time_valid = w.remote_unix_us > cfg_shadow.unix_valid_after_us;
         r.rate_status = RATE_NORMAL;
      end else begin
         events = trk_count - ring_count[ring_pos];
         span = w.local_time_ms - ring_time[ring_pos];
         ring_count[ring_pos] = trk_count;
         ring_time[ring_pos] = w.local_time_ms;
         ring_pos = (ring_pos + 1) % DEPTH;
         scaled = 128'(events) * 128'(EVENT_SCALE);
         low_bound = 128'(cfg_shadow.low_rate_limit_mhz) * 128'(span);
         high_bound = 128'(cfg_shadow.high_rate_limit_mhz) * 128'(span);
         if (events == '0)
            r.rate_status = RATE_NO_EVENTS;
         else if (scaled < low_bound)
            r.rate_status = RATE_TOO_LOW;
         else if (scaled > high_bound)
            r.rate_status = RATE_TOO_HIGH;
         else
            r.rate_status = RATE_NORMAL;
         r.events_in_window = events;
         r.window_ms = span;
         r.unix_time_valid = trk_last_unix > cfg_shadow.unix_valid_after_us;
      end
      r.tracked_offset_us = trk_offset;
      r.sync_count = trk_count;
      r.last_skew_us = trk_last_skew;
      r.skew_sum_us = trk_skew_sum;
      r.last_unix_us = trk_last_unix;
      return r;
   endfunction

   function automatic void enqueue(logic kind, logic [47:0] lt, logic [31:0] bt,
                                   logic [55:0] ut, bit hold);
      backlog_entry_type e;
      e.word.kind = kind;
      e.word.local_time_ms = lt;
      e.word.remote_boot_ms = bt;
      e.word.remote_unix_us = ut;
      e.hold = hold;
      word_backlog_q.insert(word_backlog_q.size(), e);
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // sample away from the rising edge so the driver's updates have settled
   task automatic wait_idle();
      while (word_backlog_q.size() != 0 || req_if.valid || rsp_due_q.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_config(cfg_type c);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_LOW_RATE;
      csr_wdata <= CSR_DATA_W'(c.low_rate_limit_mhz);
      @(posedge clock);
      csr_index <= CSR_HIGH_RATE;
      csr_wdata <= CSR_DATA_W'(c.high_rate_limit_mhz);
      @(posedge clock);
      csr_index <= CSR_SKEW_LIMIT;
      csr_wdata <= CSR_DATA_W'(c.skew_limit_us);
      @(posedge clock);
      csr_index <= CSR_UNIX_AFTER;
      csr_wdata <= CSR_DATA_W'(c.unix_valid_after_us);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_shadow = c;
   endtask

   // mostly steady sync streams with jitter, polls in between, some noise
   task automatic queue_traffic(int n);
      int unsigned roll, step;
      int          jit;
      logic [55:0] ut;
      bit          hold;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         hold = ($urandom_range(0, 149) == 0);
         if ($urandom_range(0, 59) == 0)
            cur_local = ($urandom_range(0, 1) == 0) ? 48'({$urandom, $urandom}) :
                        48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 100000));
         if (roll < 8) begin
            enqueue(1'($urandom), 48'({$urandom, $urandom}), 32'($urandom),
                    56'({$urandom, $urandom}), hold);
         end else if (roll < 8 + poll_pct) begin
            cur_local = cur_local + 48'($urandom_range(0, step_hi));
            enqueue(KIND_POLL, cur_local, 32'($urandom), 56'({$urandom, $urandom}), hold);
         end else begin
            step = $urandom_range(step_lo, step_hi);
            cur_local = cur_local + 48'(step);
            cur_boot = cur_boot + 32'(step);
            cur_unix = cur_unix + 56'(step) * 56'd1000;
            if ($urandom_range(0, 39) == 0)
               cur_boot = 32'($urandom);
            jit = $urandom_range(0, 2 * jitter_ms) - jitter_ms;
            case ($urandom_range(0, 3))
               0: ut = cfg_shadow.unix_valid_after_us + 56'($urandom_range(0, 2)) - 56'd1;
               1: ut = 56'({$urandom, $urandom});
               default: ut = cur_unix;
            endcase
            enqueue(KIND_SYNC, cur_local, cur_boot + 32'(jit), ut, hold);
         end
      end
   endtask

   // sender: bursts of random length, random gaps, optional hold until drained
   int unsigned       burst_left, gap_left;
   backlog_entry_type next_entry;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_if.valid && req_if.ready)
            rsp_due_q.insert(rsp_due_q.size(), advance_tracker(req_if.data));
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               req_if.valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (word_backlog_q.size() != 0 &&
                         !(word_backlog_q[0].hold && rsp_due_q.size() != 0)) begin
               next_entry = word_backlog_q.pop_front();
               req_if.valid <= 1'b1;
               req_if.data <= next_entry.word;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each word, stall on a mode that changes now and then
   rx_mode_type rx_mode = RX_OPEN;
   int unsigned rx_mode_left = 0;
   logic [2:0]  rx_beat = '0;
   rsp_type     want, got;

   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready) begin
         if (rsp_due_q.size() == 0) begin
            $error("response word with none outstanding");
            fail_count++;
         end else begin
            want = rsp_due_q.pop_front();
            got = rsp_if.data;
            check_field("tracked_offset_us", want.tracked_offset_us, got.tracked_offset_us);
            check_field("skew_us", want.skew_us, got.skew_us);
            check_field("resynced", want.resynced, got.resynced);
            check_field("unix_time_valid", want.unix_time_valid, got.unix_time_valid);
            check_field("rate_status", want.rate_status, got.rate_status);
            check_field("events_in_window", want.events_in_window, got.events_in_window);
            check_field("window_ms", want.window_ms, got.window_ms);
            check_field("sync_count", want.sync_count, got.sync_count);
            check_field("last_skew_us", want.last_skew_us, got.last_skew_us);
            check_field("skew_sum_us", want.skew_sum_us, got.skew_sum_us);
            check_field("last_unix_us", want.last_unix_us, got.last_unix_us);
         end
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(32, 256);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         rx_beat <= rx_beat + 3'd1;
         case (rx_mode)
            RX_OPEN:  rsp_if.ready <= 1'b1;
            RX_LIGHT: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: rsp_if.ready <= ($urandom_range(0, 7) == 0);
            default:  rsp_if.ready <= (rx_beat != 3'd5 && rx_beat != 3'd6);
         endcase
      end
   end

   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      cfg_type c;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      cfg_shadow.low_rate_limit_mhz = LOW_RATE_RESET;
      cfg_shadow.high_rate_limit_mhz = HIGH_RATE_RESET;
      cfg_shadow.skew_limit_us = SKEW_LIMIT_RESET;
      cfg_shadow.unix_valid_after_us = UNIX_AFTER_RESET;
      trk_offset = '0;
      trk_last_skew = '0;
      trk_skew_sum = '0;
      trk_count = '0;
      trk_last_unix = '0;
      for (int i = 0; i < DEPTH; i++) begin
         ring_time[i] = '0;
         ring_count[i] = '0;
      end
      ring_pos = 0;
      cur_local = 48'd1_700_000_000_000;
      cur_boot = 32'd5000;
      cur_unix = UNIX_AFTER_RESET + 56'd1_000_000;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed, reset configuration
      enqueue(KIND_POLL, 48'd0, 32'd0, 56'd0, 1'b0);
      enqueue(KIND_SYNC, 48'd5000, 32'd1000, UNIX_AFTER_RESET, 1'b0);
      enqueue(KIND_SYNC, 48'd5100, 32'd1100, UNIX_AFTER_RESET + 56'd1, 1'b0);
      enqueue(KIND_SYNC, 48'd7100, 32'd1100, UNIX_AFTER_RESET - 56'd1, 1'b0); // skew at limit
      enqueue(KIND_SYNC, 48'd7101, 32'd100, UNIX_AFTER_RESET, 1'b0);
      enqueue(KIND_SYNC, 48'd7200, 32'd199, UNIX_AFTER_RESET, 1'b0);
      enqueue(KIND_SYNC, 48'd7300, 32'd300, UNIX_AFTER_RESET, 1'b0);
      // hold until drained, then a zero window with events
      enqueue(KIND_POLL, 48'd7101, 32'd0, 56'd0, 1'b1);
      enqueue(KIND_POLL, 48'd1_007_101, 32'd0, 56'd0, 1'b0);
      enqueue(KIND_POLL, 48'd7301, 32'd0, 56'd0, 1'b0);
      enqueue(KIND_POLL, 48'd3, 32'hFFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 1'b0);
      enqueue(KIND_SYNC, 48'hFFFF_FFFF_FFFF, 32'd0, 56'hFF_FFFF_FFFF_FFFF, 1'b0);
      enqueue(KIND_SYNC, 48'd0, 32'hFFFF_FFFF, 56'd0, 1'b0);
      enqueue(KIND_POLL, 48'hFFFF_FFFF_FFFF, 32'd0, 56'd0, 1'b0);
      wait_idle();

      // rate exactly on both limits
      c.low_rate_limit_mhz = 20'd1000;
      c.high_rate_limit_mhz = 20'd1000;
      c.skew_limit_us = SKEW_LIMIT_RESET;
      c.unix_valid_after_us = UNIX_AFTER_RESET;
      apply_config(c);
      enqueue(KIND_SYNC, 48'd1000, 32'd0, 56'd0, 1'b0);
      enqueue(KIND_SYNC, 48'd2000, 32'd1000, 56'd0, 1'b0);
      enqueue(KIND_POLL, 48'd2000, 32'd0, 56'd0, 1'b0);
      enqueue(KIND_POLL, 48'd1999, 32'd0, 56'd0, 1'b0);
      enqueue(KIND_POLL, 48'd2001, 32'd0, 56'd0, 1'b0);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               c.low_rate_limit_mhz = LOW_RATE_RESET;
               c.high_rate_limit_mhz = HIGH_RATE_RESET;
               c.skew_limit_us = SKEW_LIMIT_RESET;
               c.unix_valid_after_us = UNIX_AFTER_RESET;
            end
            1: c = '0;
            2: begin
               c.low_rate_limit_mhz = 20'd1_000_000;
               c.high_rate_limit_mhz = 20'd1_000_000;
               c.skew_limit_us = 32'hFFFF_FFFF;
               c.unix_valid_after_us = 56'hFF_FFFF_FFFF_FFFF;
            end
            3: begin
               c.low_rate_limit_mhz = 20'd0;
               c.high_rate_limit_mhz = 20'd1_000_000;
               c.skew_limit_us = $urandom_range(0, 3_000_000);
               c.unix_valid_after_us = cur_unix;
            end
            default: begin
               c.low_rate_limit_mhz = 20'($urandom_range(0, 20000));
               c.high_rate_limit_mhz = c.low_rate_limit_mhz + 20'($urandom_range(0, 30000));
               c.skew_limit_us = ($urandom_range(0, 1) == 0) ? 32'($urandom) :
                                 32'($urandom_range(500, 5_000_000));
               c.unix_valid_after_us = cur_unix + 56'($urandom_range(0, 4_000_000))
                                       - 56'd2_000_000;
            end
         endcase
         apply_config(c);
         for (int seg = 0; seg < 5; seg++) begin
            case ($urandom_range(0, 3))
               0: begin step_lo = 1; step_hi = 60; end
               1: begin step_lo = 60; step_hi = 200; end
               2: begin step_lo = 200; step_hi = 5000; end
               default: begin step_lo = 20000; step_hi = 300000; end
            endcase
            case ($urandom_range(0, 4))
               0: jitter_ms = 0;
               1: jitter_ms = 1;
               2: jitter_ms = 400;
               3: jitter_ms = 1900;
               default: jitter_ms = 6000;
            endcase
            poll_pct = $urandom_range(5, 40);
            queue_traffic(40);
         end
         wait_idle();
      end

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
